### src/imuca_pkg.sv
// Package for the attitude estimator: shared types, widths, codes and tables.
// No dependencies; every other file imports it.
`default_nettype none
package imuca_pkg;

    localparam int RAW_W        = 16;
    localparam int FILT_W       = 21;
    localparam int TILT_W       = 25;
    localparam int ACC_W        = 32;
    localparam int DIV_W        = 45;
    localparam int DVS_W        = 19;
    localparam int RCP_W        = 36;
    localparam int SQ_W         = 42;
    localparam int ROOT_W       = 22;
    localparam int CX_W         = 34;
    localparam int CORDIC_STEPS = 22;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 24;
    localparam int IN_DATA_W    = 96;
    localparam int OUT_DATA_W   = 216;

    localparam logic signed [TILT_W-1:0] TILT_MAX = 25'sd5898240;

    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_RANGE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_RANGE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_WEIGHT  = 8'd3;

    typedef struct packed {
        logic [1:0]  accel_range;
        logic [1:0]  gyro_range;
        logic [23:0] sample_period;
        logic [15:0] blend_weight;
    } cfg_t;

    typedef struct packed {
        logic signed [FILT_W-1:0] gz;
        logic signed [FILT_W-1:0] gy;
        logic signed [FILT_W-1:0] gx;
        logic signed [RAW_W-1:0]  rz;
        logic signed [RAW_W-1:0]  ry;
        logic signed [RAW_W-1:0]  rx;
    } sample_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SUM, S_DIV, S_DIVEND, S_SQ, S_RINIT, S_ROOT, S_CINIT,
        S_CORD, S_CEND, S_GMUL, S_GM10, S_BL1, S_BL2, S_BL3, S_OUT
    } state_t;

    function automatic logic [22:0] step_angle(input logic [4:0] i);
        logic [22:0] a;
        case (i)
            5'd0:    a = 23'd2949120;
            5'd1:    a = 23'd1740967;
            5'd2:    a = 23'd919879;
            5'd3:    a = 23'd466945;
            5'd4:    a = 23'd234379;
            5'd5:    a = 23'd117304;
            5'd6:    a = 23'd58666;
            5'd7:    a = 23'd29335;
            5'd8:    a = 23'd14668;
            5'd9:    a = 23'd7334;
            5'd10:   a = 23'd3667;
            5'd11:   a = 23'd1833;
            5'd12:   a = 23'd917;
            5'd13:   a = 23'd458;
            5'd14:   a = 23'd229;
            5'd15:   a = 23'd115;
            5'd16:   a = 23'd57;
            5'd17:   a = 23'd29;
            5'd18:   a = 23'd14;
            5'd19:   a = 23'd7;
            5'd20:   a = 23'd4;
            5'd21:   a = 23'd2;
            default: a = 23'd0;
        endcase
        return a;
    endfunction

    // Tenths of a count per deg/s, times 256.
    function automatic logic [DVS_W-1:0] gyro_div(input logic [1:0] r);
        logic [DVS_W-1:0] d;
        case (r)
            2'd0:    d = 19'd335360;
            2'd1:    d = 19'd167680;
            2'd2:    d = 19'd83968;
            default: d = 19'd41984;
        endcase
        return d;
    endfunction

    // The divisor splits into a power of two, taken off first, and 655 or 41.
    function automatic logic [3:0] gyro_pre(input logic [1:0] r);
        logic [3:0] k;
        case (r)
            2'd0:    k = 4'd9;
            2'd1:    k = 4'd8;
            2'd2:    k = 4'd11;
            default: k = 4'd10;
        endcase
        return k;
    endfunction

    function automatic logic [RCP_W-1:0] gyro_rcp(input logic [1:0] r);
        logic [RCP_W-1:0] m;
        case (r)
            2'd0, 2'd1: m = 36'd53716598609;
            default:    m = 36'd13408678388;
        endcase
        return m;
    endfunction

    function automatic logic [5:0] gyro_post(input logic [1:0] r);
        logic [5:0] s;
        case (r)
            2'd0, 2'd1: s = 6'd45;
            default:    s = 6'd39;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

### src/imuca_front.sv
// Front end: accepts a sample word, scales the accelerometer counts to g.
// Depends on imuca_pkg.
`default_nettype none
module imuca_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, rate_x_raw, rate_y_raw, rate_z_raw
    input  wire logic [95:0]        s_tdata,
    input  wire logic [1:0]         accel_range,
    output logic                    push_valid,
    input  wire logic               push_ready,
    output imuca_pkg::sample_t      push_data
);
    import imuca_pkg::*;

    logic    valid_reg;
    sample_t data_reg;

    function automatic logic signed [FILT_W-1:0] scale(input logic [RAW_W-1:0] raw,
                                                       input logic [1:0] r);
        logic signed [FILT_W-1:0] e;
        e = FILT_W'($signed(raw));
        return e <<< ({1'b0, r} + 3'd2);
    endfunction

    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (push_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg.gx <= scale(s_tdata[15:0], accel_range);
            data_reg.gy <= scale(s_tdata[31:16], accel_range);
            data_reg.gz <= scale(s_tdata[47:32], accel_range);
            data_reg.rx <= $signed(s_tdata[63:48]);
            data_reg.ry <= $signed(s_tdata[79:64]);
            data_reg.rz <= $signed(s_tdata[95:80]);
        end
    end

endmodule
`default_nettype wire

### src/imuca_queue.sv
// Two-entry queue that decouples the front end from the sequencer.
// Depends on imuca_pkg.
`default_nettype none
module imuca_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire imuca_pkg::sample_t push_data,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output imuca_pkg::sample_t      pop_data
);
    import imuca_pkg::*;

    sample_t    mem [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

### src/imuca_back.sv
// Sequencer: averaging ring, square root, CORDIC, gyro integration and blend,
// built on one shared reciprocal multiplier. Depends on imuca_pkg.
`default_nettype none
module imuca_back #(
    parameter int HIST_DEPTH = 4
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire imuca_pkg::cfg_t    cfg,
    input  wire logic               pop_valid,
    output logic                    pop_ready,
    input  wire imuca_pkg::sample_t pop_data,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [215:0]            m_tdata
);
    import imuca_pkg::*;

    localparam int PW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int SUM_W = FILT_W + $clog2(HIST_DEPTH + 1);
    localparam logic [DVS_W-1:0] AVG_DIV = DVS_W'(HIST_DEPTH + 1);
    localparam int AVG_S = SUM_W + 5;
    localparam logic [RCP_W-1:0] AVG_RCP =
        RCP_W'(((64'd1 << AVG_S) + 64'(HIST_DEPTH)) / 64'(HIST_DEPTH + 1));

    state_t state_reg, state_next;

    logic signed [FILT_W-1:0] hist_x [0:HIST_DEPTH-1];
    logic signed [FILT_W-1:0] hist_y [0:HIST_DEPTH-1];
    logic signed [FILT_W-1:0] hist_z [0:HIST_DEPTH-1];
    logic [PW-1:0]            pos_reg;
    logic [PW-1:0]            cnt_reg;
    logic [1:0]               ax_reg;
    sample_t                  smp_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [RCP_W-1:0]         x_reg;
    logic [RCP_W-1:0]         rcp_reg;
    logic [5:0]               sh_reg;
    logic [71:0]              prod_reg;
    logic                     dneg_reg;
    logic                     dgyro_reg;
    logic                     dcnt_reg;
    logic signed [FILT_W-1:0] filt_reg [0:2];
    logic [SQ_W-1:0]          sq_reg [0:2];
    logic                     sel_reg;
    logic [SQ_W:0]            v_reg;
    logic [SQ_W:0]            r_reg;
    logic [SQ_W:0]            b_reg;
    logic signed [CX_W-1:0]   cx_reg;
    logic signed [CX_W-1:0]   cy_reg;
    logic signed [TILT_W-1:0] cz_reg;
    logic [4:0]               ci_reg;
    logic                     czero_reg;
    logic signed [TILT_W-1:0] tilt_reg [0:1];
    logic signed [ACC_W-1:0]  acc_reg [0:2];
    logic signed [40:0]       gp_reg;
    logic signed [48:0]       p1_reg;
    logic signed [42:0]       p2_reg;
    logic                     out_valid_reg;
    logic [215:0]             out_data_reg;

    logic signed [FILT_W-1:0] hist_sel;
    logic signed [FILT_W-1:0] g_next;
    logic signed [SUM_W-1:0]  sum_add;
    logic signed [DIV_W-1:0]  gp10;
    logic signed [DIV_W-1:0]  div_src;
    logic [DVS_W-1:0]         div_d;
    logic [DIV_W-1:0]         div_mag;
    logic [RCP_W-1:0]         div_x;
    logic [RCP_W-1:0]         div_rcp;
    logic [5:0]               div_sh;
    logic [17:0]              mul_b;
    logic [53:0]              mprod;
    logic [DIV_W-1:0]         quo;
    logic signed [DIV_W-1:0]  q_s;
    logic signed [DIV_W:0]    acc_sum;
    logic signed [ACC_W-1:0]  acc_sat;
    logic [SQ_W:0]            rb;
    logic signed [ROOT_W-1:0] yin;
    logic signed [CX_W-1:0]   dx;
    logic signed [CX_W-1:0]   dy;
    logic signed [TILT_W-1:0] ang;
    logic signed [TILT_W-1:0] tilt_new;
    logic signed [RAW_W-1:0]  rate_sel;
    logic [16:0]              wc;
    logic signed [49:0]       bsum;
    logic                     out_free;

    always_comb begin
        case (ax_reg)
            2'd0:    hist_sel = hist_x[cnt_reg];
            2'd1:    hist_sel = hist_y[cnt_reg];
            default: hist_sel = hist_z[cnt_reg];
        endcase
        case (ax_reg)
            2'd0:    g_next = smp_reg.gy;
            default: g_next = smp_reg.gz;
        endcase
        case (ax_reg)
            2'd0:    rate_sel = smp_reg.rx;
            2'd1:    rate_sel = smp_reg.ry;
            default: rate_sel = smp_reg.rz;
        endcase
        sum_add = sum_reg + SUM_W'(hist_sel);
        gp10    = (DIV_W'(gp_reg) <<< 3) + (DIV_W'(gp_reg) <<< 1);
        if (state_reg == S_GM10) begin
            div_src = gp10;
            div_d   = gyro_div(cfg.gyro_range);
        end else begin
            div_src = DIV_W'(sum_add);
            div_d   = AVG_DIV;
        end
        div_mag = (div_src[DIV_W-1] ? DIV_W'(-div_src) : DIV_W'(div_src))
                  + DIV_W'(div_d >> 1);
        if (state_reg == S_GM10) begin
            div_x   = RCP_W'(div_mag >> gyro_pre(cfg.gyro_range));
            div_rcp = gyro_rcp(cfg.gyro_range);
            div_sh  = gyro_post(cfg.gyro_range);
        end else begin
            div_x   = RCP_W'(div_mag);
            div_rcp = AVG_RCP;
            div_sh  = 6'(AVG_S);
        end
        mul_b   = dcnt_reg ? rcp_reg[35:18] : rcp_reg[17:0];
        mprod   = 54'(x_reg * mul_b);
        quo     = DIV_W'(prod_reg >> sh_reg);
        q_s     = dneg_reg ? -$signed(quo) : $signed(quo);
        acc_sum = (DIV_W+1)'(acc_reg[ax_reg]) + (DIV_W+1)'(q_s);
        if (acc_sum > (DIV_W+1)'(64'sd2147483647)) begin
            acc_sat = 32'sh7FFFFFFF;
        end else if (acc_sum < -(DIV_W+1)'(64'sd2147483648)) begin
            acc_sat = 32'sh80000000;
        end else begin
            acc_sat = acc_sum[ACC_W-1:0];
        end
        rb       = r_reg + b_reg;
        yin      = sel_reg ? -ROOT_W'(filt_reg[0]) : ROOT_W'(filt_reg[1]);
        dx       = cy_reg >>> ci_reg;
        dy       = cx_reg >>> ci_reg;
        ang      = TILT_W'(step_angle(ci_reg));
        if (czero_reg) begin
            tilt_new = '0;
        end else if (cz_reg > TILT_MAX) begin
            tilt_new = TILT_MAX;
        end else if (cz_reg < -TILT_MAX) begin
            tilt_new = -TILT_MAX;
        end else begin
            tilt_new = cz_reg;
        end
        wc       = 17'h10000 - {1'b0, cfg.blend_weight};
        bsum     = 50'(p1_reg) + 50'(p2_reg) + 50'sd32768;
        out_free = !out_valid_reg || m_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        pop_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                if (cnt_reg == PW'(HIST_DEPTH - 1)) begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (dcnt_reg) begin
                    state_next = S_DIVEND;
                end
            end
            S_DIVEND: begin
                if (!dgyro_reg) begin
                    state_next = (ax_reg == 2'd2) ? S_SQ : S_SUM;
                end else begin
                    state_next = (ax_reg == 2'd2) ? S_BL1 : S_GMUL;
                end
            end
            S_SQ: begin
                if (ax_reg == 2'd2) begin
                    state_next = S_RINIT;
                end
            end
            S_RINIT: state_next = S_ROOT;
            S_ROOT: begin
                if (b_reg[0]) begin
                    state_next = S_CINIT;
                end
            end
            S_CINIT: state_next = S_CORD;
            S_CORD: begin
                if (ci_reg == 5'(CORDIC_STEPS - 1)) begin
                    state_next = S_CEND;
                end
            end
            S_CEND:  state_next = sel_reg ? S_GMUL : S_RINIT;
            S_GMUL:  state_next = S_GM10;
            S_GM10:  state_next = S_DIV;
            S_BL1:   state_next = S_BL2;
            S_BL2:   state_next = S_BL3;
            S_BL3:   state_next = (ax_reg == 2'd1) ? S_OUT : S_BL1;
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST_DEPTH; i++) begin
                hist_x[i] <= '0;
                hist_y[i] <= '0;
                hist_z[i] <= '0;
            end
            pos_reg       <= '0;
            acc_reg[0]    <= '0;
            acc_reg[1]    <= '0;
            acc_reg[2]    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tready && state_reg != S_OUT) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    smp_reg <= pop_data;
                    sum_reg <= SUM_W'(pop_data.gx);
                    ax_reg  <= 2'd0;
                    cnt_reg <= '0;
                end
                S_SUM: begin
                    sum_reg <= sum_add;
                    cnt_reg <= cnt_reg + PW'(1);
                    if (cnt_reg == PW'(HIST_DEPTH - 1)) begin
                        x_reg     <= div_x;
                        rcp_reg   <= div_rcp;
                        sh_reg    <= div_sh;
                        dneg_reg  <= div_src[DIV_W-1];
                        dgyro_reg <= 1'b0;
                        dcnt_reg  <= 1'b0;
                    end
                end
                S_GM10: begin
                    x_reg     <= div_x;
                    rcp_reg   <= div_rcp;
                    sh_reg    <= div_sh;
                    dneg_reg  <= div_src[DIV_W-1];
                    dgyro_reg <= 1'b1;
                    dcnt_reg  <= 1'b0;
                end
                S_DIV: begin
                    if (!dcnt_reg) begin
                        prod_reg <= 72'(mprod);
                    end else begin
                        prod_reg <= prod_reg + (72'(mprod) << 18);
                    end
                    dcnt_reg <= !dcnt_reg;
                end
                S_DIVEND: begin
                    ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                    if (!dgyro_reg) begin
                        filt_reg[ax_reg] <= q_s[FILT_W-1:0];
                        case (ax_reg)
                            2'd0:    hist_x[pos_reg] <= q_s[FILT_W-1:0];
                            2'd1:    hist_y[pos_reg] <= q_s[FILT_W-1:0];
                            default: hist_z[pos_reg] <= q_s[FILT_W-1:0];
                        endcase
                        sum_reg <= SUM_W'(g_next);
                        cnt_reg <= '0;
                        if (ax_reg == 2'd2) begin
                            pos_reg <= (pos_reg == PW'(HIST_DEPTH - 1)) ? '0
                                                                          : pos_reg + PW'(1);
                            sel_reg <= 1'b0;
                        end
                    end else begin
                        acc_reg[ax_reg] <= acc_sat;
                    end
                end
                S_SQ: begin
                    sq_reg[ax_reg] <= SQ_W'(filt_reg[ax_reg] * filt_reg[ax_reg]);
                    ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                end
                S_RINIT: begin
                    v_reg <= sel_reg ? (SQ_W+1)'(sq_reg[1]) + (SQ_W+1)'(sq_reg[2])
                                     : (SQ_W+1)'(sq_reg[2]) + (SQ_W+1)'(sq_reg[0]);
                    r_reg <= '0;
                    b_reg <= (SQ_W+1)'(1) << (SQ_W - 2);
                end
                S_ROOT: begin
                    if (v_reg >= rb) begin
                        v_reg <= v_reg - rb;
                        r_reg <= (r_reg >> 1) + b_reg;
                    end else begin
                        r_reg <= r_reg >> 1;
                    end
                    b_reg <= b_reg >> 2;
                end
                S_CINIT: begin
                    cx_reg    <= CX_W'($signed({1'b0, r_reg[ROOT_W-1:0]})) <<< 8;
                    cy_reg    <= CX_W'(yin) <<< 8;
                    cz_reg    <= '0;
                    ci_reg    <= '0;
                    czero_reg <= (r_reg == '0) && (yin == '0);
                end
                S_CORD: begin
                    if (!cy_reg[CX_W-1]) begin
                        cx_reg <= cx_reg + dx;
                        cy_reg <= cy_reg - dy;
                        cz_reg <= cz_reg + ang;
                    end else begin
                        cx_reg <= cx_reg - dx;
                        cy_reg <= cy_reg + dy;
                        cz_reg <= cz_reg - ang;
                    end
                    ci_reg <= ci_reg + 5'd1;
                end
                S_CEND: begin
                    tilt_reg[sel_reg] <= tilt_new;
                    sel_reg <= !sel_reg;
                    ax_reg  <= 2'd0;
                end
                S_GMUL: begin
                    gp_reg <= 41'(rate_sel * $signed({1'b0, cfg.sample_period}));
                end
                S_BL1: begin
                    p1_reg <= 49'($signed({1'b0, cfg.blend_weight}) * acc_reg[ax_reg]);
                end
                S_BL2: begin
                    p2_reg <= 43'($signed({1'b0, wc}) * tilt_reg[ax_reg[0]]);
                end
                S_BL3: begin
                    acc_reg[ax_reg] <= bsum[47:16];
                    ax_reg <= (ax_reg == 2'd1) ? 2'd0 : ax_reg + 2'd1;
                end
                S_OUT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {7'd0, filt_reg[2], filt_reg[1], filt_reg[0],
                                          tilt_reg[1], tilt_reg[0],
                                          acc_reg[2], acc_reg[1], acc_reg[0]};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < PW'(HIST_DEPTH) || HIST_DEPTH == (1 << PW))
        else $error("ring position out of range");
    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == S_OUT)
        else $error("result raised outside the output step");
    a_tilt_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BL2) |-> (tilt_reg[ax_reg[0]] <= TILT_MAX &&
                                  tilt_reg[ax_reg[0]] >= -TILT_MAX))
        else $error("tilt angle beyond clamp");
    a_cordic_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CORD) |-> ci_reg < 5'(CORDIC_STEPS))
        else $error("CORDIC step count overrun");

endmodule
`default_nettype wire

### src/imu_complementary_attitude.sv
// Top level of the attitude estimator: configuration registers, front end,
// queue and sequencer. Depends on imuca_pkg, imuca_front, imuca_queue, imuca_back.
//
//   channel   direction  word                         handshake
//   s_*       in         one six-axis sample (96 b)   s_tvalid / s_tready
//   m_*       out        one attitude result (216 b)  m_tvalid / m_tready
//   cfg_*     in         register index and data      cfg_valid / cfg_ready
//
// The sequencer takes one sample at a time; its time per sample grows with HIST_DEPTH
// and is set mostly by the two root and CORDIC passes; the six divisions each run on
// a two-pass reciprocal multiplier. Reset is synchronous and clears the ring, angles
// and registers. A two-entry queue and the front register take up to three samples
// while the sequencer is busy; a stalled result waits in the output register.
`default_nettype none
module imu_complementary_attitude #(
    parameter int HIST_DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, rate_x_raw, rate_y_raw, rate_z_raw
    input  wire logic [95:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // roll_deg, pitch_deg, yaw_deg, tilt_roll_deg, tilt_pitch_deg,
    // filt_accel_x, filt_accel_y, filt_accel_z, zero fill
    output logic [215:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [23:0]  cfg_data
);
    import imuca_pkg::*;

    cfg_t    cfg_reg;
    logic    push_valid;
    logic    push_ready;
    sample_t push_data;
    logic    pop_valid;
    logic    pop_ready;
    sample_t pop_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.accel_range   <= 2'd0;
            cfg_reg.gyro_range    <= 2'd0;
            cfg_reg.sample_period <= 24'd167772;
            cfg_reg.blend_weight  <= 16'd64225;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ACCEL_RANGE:   cfg_reg.accel_range   <= cfg_data[1:0];
                CFG_GYRO_RANGE:    cfg_reg.gyro_range    <= cfg_data[1:0];
                CFG_SAMPLE_PERIOD: cfg_reg.sample_period <= cfg_data;
                CFG_BLEND_WEIGHT:  cfg_reg.blend_weight  <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    imuca_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .accel_range (cfg_reg.accel_range),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    imuca_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    imuca_back #(
        .HIST_DEPTH (HIST_DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
`default_nettype wire
